[rtl/core/pru_pkg.sv]
// Shared types, constants and the factorial table for the permutation rank/unrank block.
package pru_pkg;

    localparam int NIBBLE_W         = 4;
    localparam int VALUES           = 16;
    localparam int PERM_W           = 48;
    localparam int RANK_W           = 29;
    localparam int WORD_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 12;

    localparam logic OP_RANK   = 1'b0;
    localparam logic OP_UNRANK = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_PERM   = 2'd1;
    localparam logic [1:0] ST_RANK_RANGE = 2'd2;

    localparam logic UOP_MAC = 1'b0;
    localparam logic UOP_SUB = 1'b1;

    typedef struct packed {
        logic                uop;
        logic [WORD_W-1:0]   a;
        logic [WORD_W-1:0]   b;
        logic [NIBBLE_W-1:0] digit;
    } unit_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              ge;
    } unit_rsp_t;

    function automatic logic [WORD_W-1:0] fact(input logic [NIBBLE_W-1:0] idx);
        logic [WORD_W-1:0] f;
        case (idx)
            4'd0:    f = 32'd1;
            4'd1:    f = 32'd1;
            4'd2:    f = 32'd2;
            4'd3:    f = 32'd6;
            4'd4:    f = 32'd24;
            4'd5:    f = 32'd120;
            4'd6:    f = 32'd720;
            4'd7:    f = 32'd5040;
            4'd8:    f = 32'd40320;
            4'd9:    f = 32'd362880;
            4'd10:   f = 32'd3628800;
            4'd11:   f = 32'd39916800;
            4'd12:   f = 32'd479001600;
            default: f = 32'd1;
        endcase
        return f;
    endfunction

endpackage

[rtl/core/pru_unit.sv]
// Shared arithmetic unit: multiply-accumulate and compare-subtract.
module pru_unit
    import pru_pkg::*;
(
    input  unit_req_t req,
    output unit_rsp_t rsp
);

    logic [WORD_W-1:0] prod;
    logic [WORD_W:0]   diff;

    always_comb
    begin
        prod = req.b * WORD_W'(req.digit);
        diff = {1'b0, req.a} - {1'b0, req.b};
        rsp.ge = ~diff[WORD_W];
        case (req.uop)
            UOP_MAC: rsp.result = req.a + prod;
            default: rsp.result = diff[WORD_W-1:0];
        endcase
    end

endmodule

[rtl/core/pru_pick.sv]
// Free-value counting: Lehmer digit of an element and the digit-th unused value.
module pru_pick
    import pru_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic [VALUES-1:0]   used,
    input  logic [NIBBLE_W-1:0] elem,
    input  logic [NIBBLE_W-1:0] digit,
    output logic [NIBBLE_W-1:0] pick,
    output logic [NIBBLE_W-1:0] rank_digit
);

    logic [NIBBLE_W-1:0] below [VALUES];

    always_comb
    begin
        for (int v = 0; v < VALUES; v++)
        begin
            below[v] = NIBBLE_W'($countones(used & ((VALUES'(1) << v) - VALUES'(1))));
        end
        rank_digit = elem - below[elem];
        pick = '0;
        for (int v = MAX_ELEMENTS - 1; v >= 0; v--)
        begin
            if (!used[v] && ((NIBBLE_W'(v) - below[v]) == digit))
            begin
                pick = NIBBLE_W'(v);
            end
        end
    end

endmodule

[rtl/core/permutation_rank_unrank.sv]
// Permutation rank/unrank top level: sequencer, working registers and output register.
// One transaction at a time. Ranking (op 0) walks the positions once, one per cycle,
// checking each element and adding its Lehmer digit times the factorial (n-1-pos)! in the
// shared multiply-accumulate unit. Unranking
// (op 1) first checks the rank against n!, then per position takes four
// compare-subtract steps of a restoring division by the factorial weight in the shared
// unit and one step to pick the digit-th unused value.
// A finished result sits in the output register, so the next transaction is taken
// while it waits; a result that meets a still-full output register holds until it drains.
module permutation_rank_unrank
    import pru_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [3:0]          element_count,
    input  logic [PERM_W-1:0]   perm_in,
    input  logic [RANK_W-1:0]   rank_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [RANK_W-1:0]   rank_out,
    output logic [PERM_W-1:0]   perm_out,
    output logic [1:0]          status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RANK  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PICK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                op_reg, op_next;
    logic [3:0]          n_reg, n_next;
    logic [PERM_W-1:0]   perm_reg, perm_next;
    logic [WORD_W-1:0]   r_reg, r_next;
    logic [RANK_W-1:0]   acc_reg, acc_next;
    logic [VALUES-1:0]   seen_reg, seen_next;
    logic [3:0]          pos_reg, pos_next;
    logic [1:0]          bit_reg, bit_next;
    logic [3:0]          digit_reg, digit_next;
    logic [1:0]          st_reg, st_next;
    logic [PERM_W-1:0]   pacc_reg, pacc_next;
    logic [RANK_W-1:0]   rank_out_reg, rank_out_next;
    logic [PERM_W-1:0]   perm_out_reg, perm_out_next;
    logic [1:0]          status_reg, status_next;

    logic [3:0]          n_clamped;
    logic [3:0]          elem;
    logic [3:0]          weight_idx;
    logic                last_pos;
    logic [3:0]          pick;
    logic [3:0]          rank_digit;
    unit_req_t           ureq;
    unit_rsp_t           ursp;

    pru_unit u_unit
    (
        .req (ureq),
        .rsp (ursp)
    );

    pru_pick #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_pick
    (
        .used       (seen_reg),
        .elem       (elem),
        .digit      (digit_reg),
        .pick       (pick),
        .rank_digit (rank_digit)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign rank_out  = rank_out_reg;
    assign perm_out  = perm_out_reg;
    assign status    = status_reg;

    always_comb
    begin
        if (element_count == 4'd0)
            n_clamped = 4'd1;
        else if (element_count > 4'(MAX_ELEMENTS))
            n_clamped = 4'(MAX_ELEMENTS);
        else
            n_clamped = element_count;
    end

    assign elem       = perm_reg[{pos_reg, 2'b00} +: NIBBLE_W];
    assign weight_idx = n_reg - 4'd1 - pos_reg;
    assign last_pos   = (pos_reg == n_reg - 4'd1);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        n_next         = n_reg;
        perm_next      = perm_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        seen_next      = seen_reg;
        pos_next       = pos_reg;
        bit_next       = bit_reg;
        digit_next     = digit_reg;
        st_next        = st_reg;
        pacc_next      = pacc_reg;
        rank_out_next  = rank_out_reg;
        perm_out_next  = perm_out_reg;
        status_next    = status_reg;

        ureq.uop   = UOP_SUB;
        ureq.a     = r_reg;
        ureq.b     = fact(weight_idx) << bit_reg;
        ureq.digit = rank_digit;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    n_next     = n_clamped;
                    perm_next  = perm_in;
                    r_next     = WORD_W'(rank_in);
                    acc_next   = '0;
                    seen_next  = '0;
                    pos_next   = '0;
                    bit_next   = 2'd3;
                    digit_next = '0;
                    st_next    = ST_OK;
                    pacc_next  = '0;
                    state_next = (op == OP_UNRANK) ? S_CHECK : S_RANK;
                end
            end
            S_RANK:
            begin
                ureq.uop = UOP_MAC;
                ureq.a   = WORD_W'(acc_reg);
                ureq.b   = fact(weight_idx);
                acc_next = ursp.result[RANK_W-1:0];
                if (elem >= n_reg || seen_reg[elem])
                    st_next = ST_NOT_PERM;
                seen_next = seen_reg | (VALUES'(1) << elem);
                if (last_pos)
                    state_next = S_DONE;
                else
                    pos_next = pos_reg + 4'd1;
            end
            S_CHECK:
            begin
                ureq.b = fact(n_reg);
                if (ursp.ge)
                begin
                    st_next    = ST_RANK_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (ursp.ge)
                begin
                    r_next              = ursp.result;
                    digit_next[bit_reg] = 1'b1;
                end
                if (bit_reg == 2'd0)
                    state_next = S_PICK;
                else
                    bit_next = bit_reg - 2'd1;
            end
            S_PICK:
            begin
                seen_next                            = seen_reg | (VALUES'(1) << pick);
                pacc_next[{pos_reg, 2'b00} +: NIBBLE_W] = pick;
                if (last_pos)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next   = pos_reg + 4'd1;
                    bit_next   = 2'd3;
                    digit_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    rank_out_next  = (op_reg == OP_RANK && st_reg == ST_OK) ? acc_reg : '0;
                    perm_out_next  = (op_reg == OP_UNRANK && st_reg == ST_OK) ? pacc_reg : '0;
                    status_next    = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        n_reg        <= n_next;
        perm_reg     <= perm_next;
        r_reg        <= r_next;
        acc_reg      <= acc_next;
        seen_reg     <= seen_next;
        pos_reg      <= pos_next;
        bit_reg      <= bit_next;
        digit_reg    <= digit_next;
        st_reg       <= st_next;
        pacc_reg     <= pacc_next;
        rank_out_reg <= rank_out_next;
        perm_out_reg <= perm_out_next;
        status_reg   <= status_next;
    end

endmodule
